// ===== rtl/tlbt_pkg.sv =====
// ----------------------------------------------------------------------------
// tlbt_pkg
// Shared types and constants of the page translator core.
// ----------------------------------------------------------------------------
package tlbt_pkg;

    localparam int unsigned ADDR_W      = 16;
    localparam int unsigned CFG_W       = 9;
    localparam int unsigned OFFSET_BITS = 8;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN_RD,
        ST_SCAN_CMP,
        ST_DECIDE,
        ST_SHIFT_RD,
        ST_SHIFT_WR,
        ST_TAIL_WR,
        ST_OUT
    } state_t;

endpackage

// ===== rtl/tlb_lru_page_translator_core.sv =====
// ----------------------------------------------------------------------------
// tlb_lru_page_translator_core
// Virtual-to-physical translator: FIFO-refilled TLB in front of an LRU list.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one virtual address per beat; m_axis returns one result
//   beat per address. cfg_valid/cfg_ready writes frame_count (9 bits); ready
//   is high only while the sequencer is idle. 0 acts as 1, values above
//   MAX_FRAMES as MAX_FRAMES.
//   Each address runs through a sequencer around the resident-list memory
//   (page and frame, one read port, one write port, registered read): a
//   search that reads and compares one entry at a time (ST_SCAN_RD,
//   ST_SCAN_CMP), then a shift that reads and writes back each entry above
//   the touched position (ST_SHIFT_RD, ST_SHIFT_WR), plus the control states
//   ST_IDLE, ST_DECIDE, ST_TAIL_WR and ST_OUT. The result is registered as it
//   leaves ST_OUT, and the next address can be taken in the cycle after.
//   The TLB lookup itself is a parallel compare over TLB_DEPTH registers.
//   A stalled result holds m_tvalid and m_tdata until taken; meanwhile the
//   next address is accepted and worked on, and its result waits in the last
//   state until the output register is free.
//   Reset clears the TLB valid bits, the fill pointer and both counters and
//   sets frame_count to 256; the list memory needs no clearing, as only
//   entries below the count are read.
// ----------------------------------------------------------------------------
module tlb_lru_page_translator_core #(
    parameter int unsigned TLB_DEPTH   = 16,
    parameter int unsigned MAX_FRAMES  = 256
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [tlbt_pkg::ADDR_W-1:0] s_tdata,   // [15:0] vaddr
    output logic                       m_tvalid,
    input  logic                       m_tready,
    // [15:0] paddr, [16] tlb_hit, [17] fault, [18] evicted,
    // [26:19] evicted_page, [31:27] zero
    output logic [31:0]                m_tdata,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [tlbt_pkg::CFG_W-1:0] cfg_data
);
    import tlbt_pkg::*;

    localparam int unsigned PAGE_W = ADDR_W - OFFSET_BITS;
    localparam int unsigned IDX_W  = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int unsigned CNT_W  = $clog2(MAX_FRAMES + 1);
    localparam int unsigned TLB_W  = (TLB_DEPTH > 1) ? $clog2(TLB_DEPTH) : 1;
    localparam int unsigned FR_W   = PAGE_W;

    state_t state_reg, state_next;

    logic [CFG_W-1:0]        frame_count_reg;
    logic [TLB_DEPTH-1:0]    tlb_valid_reg;
    logic [PAGE_W-1:0]       tlb_page_reg  [TLB_DEPTH];
    logic [FR_W-1:0]         tlb_frame_reg [TLB_DEPTH];
    logic [TLB_W-1:0]        tlb_next_reg;
    logic [CNT_W-1:0]        resident_reg;
    logic [CNT_W-1:0]        used_reg;

    logic [PAGE_W-1:0]       lru_page_mem  [MAX_FRAMES];
    logic [FR_W-1:0]         lru_frame_mem [MAX_FRAMES];
    logic [PAGE_W-1:0]       rd_page_reg;
    logic [FR_W-1:0]         rd_frame_reg;

    logic [ADDR_W-1:0]       va_reg;
    logic [CNT_W-1:0]        idx_reg;       // scan / shift position
    logic                    found_reg;
    logic                    hit_reg;
    logic                    fault_reg;
    logic                    ev_reg;
    logic [PAGE_W-1:0]       ev_page_reg;
    logic [FR_W-1:0]         frame_reg;
    logic [PAGE_W-1:0]       mv_page_reg;   // entry carried to the tail
    logic [FR_W-1:0]         mv_frame_reg;
    logic [PAGE_W-1:0]       head_page_reg; // list entry 0, as the search read it
    logic [FR_W-1:0]         head_frame_reg;
    logic                    m_tvalid_reg;
    logic [31:0]             m_tdata_reg;

    logic [PAGE_W-1:0]       page;
    logic                    tlb_found;
    logic [FR_W-1:0]         tlb_fr;
    logic [CNT_W:0]          limit;
    logic                    append_ok;
    logic                    out_fire;
    logic                    rd_en;
    logic [IDX_W-1:0]        rd_addr;
    logic                    wr_en;
    logic [IDX_W-1:0]        wr_addr;
    logic [PAGE_W-1:0]       wr_page;
    logic [FR_W-1:0]         wr_frame;

    assign page = va_reg[ADDR_W-1:OFFSET_BITS];

    always_comb begin
        tlb_found = 1'b0;
        tlb_fr    = '0;
        for (int i = TLB_DEPTH - 1; i >= 0; i--) begin
            if (tlb_valid_reg[i] && tlb_page_reg[i] == page) begin
                tlb_found = 1'b1;
                tlb_fr    = tlb_frame_reg[i];
            end
        end
    end

    always_comb begin
        if (frame_count_reg == '0) begin
            limit = (CNT_W + 1)'(1);
        end else if ({1'b0, frame_count_reg} > (CFG_W + 1)'(MAX_FRAMES)) begin
            limit = (CNT_W + 1)'(MAX_FRAMES);
        end else begin
            limit = (CNT_W + 1)'(frame_count_reg);
        end
    end

    // a fresh frame is free; otherwise a fault evicts the head
    assign append_ok = ({1'b0, used_reg} < limit) && (resident_reg < CNT_W'(MAX_FRAMES));
    assign out_fire  = (state_reg == ST_OUT) && (!m_tvalid_reg || m_tready);

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = (state_reg == ST_IDLE);
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid && s_tready) begin
                    state_next = ST_SCAN_RD;
                end
            end
            ST_SCAN_RD: begin
                if (idx_reg >= resident_reg) begin
                    state_next = ST_DECIDE;
                end else begin
                    state_next = ST_SCAN_CMP;
                end
            end
            ST_SCAN_CMP: begin
                if (rd_page_reg == page) begin
                    state_next = ST_DECIDE;
                end else begin
                    state_next = ST_SCAN_RD;
                end
            end
            ST_DECIDE: begin
                if (found_reg || !append_ok) begin
                    state_next = ST_SHIFT_RD;
                end else begin
                    state_next = ST_OUT;
                end
            end
            ST_SHIFT_RD: begin
                if (idx_reg + 1'b1 >= resident_reg) begin
                    state_next = ST_TAIL_WR;
                end else begin
                    state_next = ST_SHIFT_WR;
                end
            end
            ST_SHIFT_WR: state_next = ST_SHIFT_RD;
            ST_TAIL_WR:  state_next = ST_OUT;
            ST_OUT: begin
                // hold the finished result until the output register frees
                if (out_fire) begin
                    state_next = ST_IDLE;
                end
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    // memory port control
    always_comb begin
        rd_en    = 1'b0;
        rd_addr  = idx_reg[IDX_W-1:0];
        wr_en    = 1'b0;
        wr_addr  = idx_reg[IDX_W-1:0];
        wr_page  = rd_page_reg;
        wr_frame = rd_frame_reg;
        unique case (state_reg)
            ST_SCAN_RD:  rd_en = (idx_reg < resident_reg);
            ST_SHIFT_RD: begin
                rd_en   = (idx_reg + 1'b1 < resident_reg);
                rd_addr = IDX_W'(idx_reg + 1'b1);
            end
            ST_SHIFT_WR: wr_en = 1'b1;
            ST_TAIL_WR: begin
                wr_en    = 1'b1;
                wr_addr  = IDX_W'(resident_reg - 1'b1);
                wr_page  = mv_page_reg;
                wr_frame = mv_frame_reg;
            end
            ST_DECIDE: begin
                // fresh frame appended at the tail
                wr_en    = !found_reg && append_ok;
                wr_addr  = resident_reg[IDX_W-1:0];
                wr_page  = page;
                wr_frame = FR_W'(used_reg);
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_page_reg  <= lru_page_mem[rd_addr];
            rd_frame_reg <= lru_frame_mem[rd_addr];
        end
        if (wr_en) begin
            lru_page_mem[wr_addr]  <= wr_page;
            lru_frame_mem[wr_addr] <= wr_frame;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            frame_count_reg <= CFG_W'(256);
            tlb_valid_reg   <= '0;
            tlb_next_reg    <= '0;
            resident_reg    <= '0;
            used_reg        <= '0;
            m_tvalid_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready) begin
                frame_count_reg <= cfg_data;
            end
            if (out_fire) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid && s_tready) begin
                        va_reg    <= s_tdata;
                        idx_reg   <= '0;
                        found_reg <= 1'b0;
                        hit_reg   <= 1'b0;
                        fault_reg <= 1'b0;
                        ev_reg    <= 1'b0;
                        ev_page_reg <= '0;
                    end
                end
                ST_SCAN_RD: begin
                    if (idx_reg == '0) begin
                        hit_reg   <= tlb_found;
                        frame_reg <= tlb_fr;
                    end
                end
                ST_SCAN_CMP: begin
                    if (idx_reg == '0) begin
                        head_page_reg  <= rd_page_reg;
                        head_frame_reg <= rd_frame_reg;
                    end
                    if (rd_page_reg == page) begin
                        found_reg    <= 1'b1;
                        mv_page_reg  <= rd_page_reg;
                        mv_frame_reg <= rd_frame_reg;
                        if (!hit_reg) begin
                            frame_reg <= rd_frame_reg;
                        end
                    end else begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                ST_DECIDE: begin
                    if (!found_reg) begin
                        fault_reg <= 1'b1;
                        if (append_ok) begin
                            frame_reg    <= FR_W'(used_reg);
                            used_reg     <= used_reg + 1'b1;
                            resident_reg <= resident_reg + 1'b1;
                        end else begin
                            // evict the head: new page takes its frame, stale
                            // translations drop out of the TLB
                            ev_reg       <= 1'b1;
                            ev_page_reg  <= head_page_reg;
                            frame_reg    <= head_frame_reg;
                            mv_page_reg  <= page;
                            mv_frame_reg <= head_frame_reg;
                            idx_reg      <= '0;
                            for (int i = 0; i < TLB_DEPTH; i++) begin
                                if (tlb_page_reg[i] == head_page_reg) begin
                                    tlb_valid_reg[i] <= 1'b0;
                                end
                            end
                        end
                    end
                end
                ST_SHIFT_RD: ;
                ST_SHIFT_WR: idx_reg <= idx_reg + 1'b1;
                ST_TAIL_WR:  ;
                ST_OUT: begin
                    if (out_fire) begin
                        m_tdata_reg  <= {5'd0, ev_page_reg, ev_reg, fault_reg, hit_reg,
                                         ADDR_W'({frame_reg, va_reg[OFFSET_BITS-1:0]})};
                        if (!hit_reg) begin
                            tlb_valid_reg[tlb_next_reg] <= 1'b1;
                            tlb_page_reg[tlb_next_reg]  <= page;
                            tlb_frame_reg[tlb_next_reg] <= frame_reg;
                            tlb_next_reg <= (tlb_next_reg == TLB_W'(TLB_DEPTH - 1)) ?
                                            '0 : tlb_next_reg + 1'b1;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_cnt: assert property (@(posedge aclk) disable iff (!aresetn)
        resident_reg <= CNT_W'(MAX_FRAMES))
        else $error("resident count overflow");
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("accepted while busy");
    a_used: assert property (@(posedge aclk) disable iff (!aresetn)
        used_reg == resident_reg)
        else $error("frame count and list length disagree");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("result beat changed while stalled");
`endif

endmodule

// ===== tb/tlb_lru_page_translator_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlb_lru_page_translator_core_tb
// Drives virtual addresses into the translator, with random gaps on the input
// side and random stalls on the result side. A behavioural copy of the TLB
// and the LRU resident list predicts every result beat, and each received
// beat is compared field by field. frame_count is rewritten between phases,
// taking in the extremes 0, 1 and 256 and values beyond 256.
// ----------------------------------------------------------------------------
module tlb_lru_page_translator_core_tb;
    import tlbt_pkg::*;

    localparam int TLB_N      = 16;
    localparam int FRAMES_MAX = 256;
    localparam int OFS_BITS   = 8;
    localparam int CYCLE_LIMIT = 5000000;

    typedef struct packed {
        logic [7:0]  evicted_page;
        logic        evicted;
        logic        fault;
        logic        tlb_hit;
        logic [15:0] phys_addr;
    } xlat_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [ADDR_W-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_W-1:0] cfg_data = '0;

    tlb_lru_page_translator_core uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // predictor state
    logic [8:0] frame_cfg;
    logic       tlb_v [TLB_N];
    logic [7:0] tlb_pg [TLB_N];
    logic [7:0] tlb_fr [TLB_N];
    int         tlb_ptr;
    logic [7:0] res_pg [FRAMES_MAX];
    logic [7:0] res_fr [FRAMES_MAX];
    int         res_cnt;
    int         used_cnt;

    xlat_t expected_xlat [$];
    int    mismatches = 0;
    int    beats_out = 0;
    int    faults_seen = 0;
    int    evictions_seen = 0;
    int    hits_seen = 0;
    int    cycles = 0;
    int    hold_off = 0;
    int    rx_wait = 0;
    int    stall_max = 12;
    logic  [7:0] hot_pages [8];

    function automatic int frame_cap();
        if (frame_cfg == 0) return 1;
        if (frame_cfg > FRAMES_MAX) return FRAMES_MAX;
        return frame_cfg;
    endfunction

    function automatic int res_lookup(logic [7:0] pg);
        for (int i = 0; i < res_cnt; i++)
            if (res_pg[i] == pg) return i;
        return res_cnt;
    endfunction

    function automatic void res_promote(int pos);
        logic [7:0] p, f;
        if (pos >= res_cnt) return;
        p = res_pg[pos];
        f = res_fr[pos];
        for (int i = pos; i + 1 < res_cnt; i++) begin
            res_pg[i] = res_pg[i + 1];
            res_fr[i] = res_fr[i + 1];
        end
        res_pg[res_cnt - 1] = p;
        res_fr[res_cnt - 1] = f;
    endfunction

    function automatic void tlb_load(logic [7:0] pg, logic [7:0] fr);
        tlb_v[tlb_ptr] = 1'b1;
        tlb_pg[tlb_ptr] = pg;
        tlb_fr[tlb_ptr] = fr;
        tlb_ptr = (tlb_ptr + 1) % TLB_N;
    endfunction

    function automatic xlat_t translate(logic [15:0] va);
        xlat_t r;
        logic [7:0] pg, fr;
        logic found;
        int pos;
        pg = va[15:OFS_BITS];
        fr = '0;
        found = 1'b0;
        r = '0;
        for (int i = 0; i < TLB_N; i++)
            if (!found && tlb_v[i] && tlb_pg[i] == pg) begin
                fr = tlb_fr[i];
                found = 1'b1;
            end
        if (found) begin
            r.tlb_hit = 1'b1;
            res_promote(res_lookup(pg));
        end else begin
            pos = res_lookup(pg);
            if (pos < res_cnt) begin
                fr = res_fr[pos];
                tlb_load(pg, fr);
                res_promote(pos);
            end else begin
                r.fault = 1'b1;
                if (used_cnt < frame_cap() && res_cnt < FRAMES_MAX) begin
                    fr = used_cnt[7:0];
                    used_cnt++;
                    res_pg[res_cnt] = pg;
                    res_fr[res_cnt] = fr;
                    res_cnt++;
                end else begin
                    r.evicted = 1'b1;
                    r.evicted_page = res_pg[0];
                    fr = res_fr[0];
                    res_pg[0] = pg;
                    res_promote(0);
                    for (int i = 0; i < TLB_N; i++)
                        if (tlb_v[i] && tlb_pg[i] == r.evicted_page) tlb_v[i] = 1'b0;
                end
                tlb_load(pg, fr);
            end
        end
        r.phys_addr = {fr, va[OFS_BITS-1:0]};
        return r;
    endfunction

    // result side: a drawn wait after each beat, optional long hold-off
    always @(negedge aclk) begin
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            m_tready <= 1'b0;
        end else if (rx_wait > 0) begin
            rx_wait <= rx_wait - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        xlat_t got, want;
        cycles <= cycles + 1;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata[26:0];
            beats_out <= beats_out + 1;
            rx_wait <= $urandom_range(0, stall_max);
            if (expected_xlat.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result beat %h", m_tdata);
            end else begin
                want = expected_xlat.pop_front();
                if (got != want || m_tdata[31:27] != 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("mismatch: exp pa=%h hit=%b flt=%b ev=%b evp=%h",
                            want.phys_addr, want.tlb_hit, want.fault,
                            want.evicted, want.evicted_page);
                        $display("          got pa=%h hit=%b flt=%b ev=%b evp=%h top=%h",
                            got.phys_addr, got.tlb_hit, got.fault,
                            got.evicted, got.evicted_page, m_tdata[31:27]);
                    end
                end
                if (want.tlb_hit) hits_seen <= hits_seen + 1;
                if (want.fault) faults_seen <= faults_seen + 1;
                if (want.evicted) evictions_seen <= evictions_seen + 1;
            end
        end
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("[tlb_lru_page_translator_core] ERROR");
            $finish;
        end
    end

    // leaves the beat offered after acceptance; the next call replaces it or
    // drops it, and drain() drops it
    task automatic send_address(logic [15:0] va, bit gaps = 1'b1);
        int gap;
        gap = gaps ? $urandom_range(0, 12) : 0;
        if (gap > 0 && $urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= va;
        do @(posedge aclk); while (!s_tready);
        expected_xlat.push_back(translate(va));
        @(negedge aclk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (expected_xlat.size() != 0) @(negedge aclk);
        @(negedge aclk);
    endtask

    task automatic write_frame_count(logic [8:0] value);
        drain();
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do @(posedge aclk); while (!cfg_ready);
        frame_cfg = value;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [15:0] hot_address();
        return {hot_pages[$urandom_range(0, 7)], 8'($urandom)};
    endfunction

    task automatic test_directed();
        send_address(16'h0000);
        send_address(16'h00FF);
        send_address(16'hFFFF);
        send_address(16'hFF00);
        send_address(16'h0000);
        send_address(16'hAA55);
        send_address(16'h55AA);
        send_address(16'hFF7F);
        for (int i = 1; i <= 17; i++) send_address({8'(i), 8'(i * 13)});
    endtask

    // tiny frame budget: every fault evicts, TLB entries get invalidated
    task automatic test_small_frames();
        write_frame_count(9'd0);
        repeat (20) send_address({8'($urandom_range(0, 3)), 8'($urandom)});
        write_frame_count(9'd1);
        repeat (20) send_address({8'($urandom_range(0, 3)), 8'($urandom)});
        write_frame_count(9'd4);
        repeat (80) send_address({8'($urandom_range(0, 7)), 8'($urandom)});
    endtask

    // fill the receiver up while inputs keep coming, then pause to empty
    task automatic test_backpressure();
        hold_off = 400;
        repeat (6) send_address(16'($urandom), 1'b0);
        drain();
        stall_max = 0;
        repeat (20) send_address(hot_address(), 1'b0);
        stall_max = 12;
    endtask

    task automatic test_random(int n);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 31) == 0) hot_pages[$urandom_range(0, 7)] = 8'($urandom);
            case ($urandom_range(0, 3))
                0: send_address(16'($urandom));
                default: send_address(hot_address());
            endcase
        end
    endtask

    task automatic test_lowered_budget();
        write_frame_count(9'd300);
        repeat (60) send_address(16'($urandom));
        // below frames in use: every later fault evicts
        write_frame_count(9'd8);
        repeat (60) send_address({8'($urandom_range(0, 15)), 8'($urandom)});
        write_frame_count(9'd511);
        test_random(150);
        write_frame_count(9'd256);
        test_random(150);
    endtask

    initial begin
        frame_cfg = 9'd256;
        tlb_ptr = 0;
        res_cnt = 0;
        used_cnt = 0;
        foreach (tlb_v[i]) tlb_v[i] = 1'b0;
        foreach (hot_pages[i]) hot_pages[i] = 8'($urandom);
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        test_directed();
        test_random(150);
        test_backpressure();
        test_small_frames();
        test_lowered_budget();
        drain();
        $display("covered %0d result beats: %0d TLB hits, %0d faults, %0d evictions",
            beats_out, hits_seen, faults_seen, evictions_seen);
        $display("frame_count settings 0, 1, 4, 8, 256, 300, 511; long result stall included");
        if (mismatches == 0 && expected_xlat.size() == 0) begin
            $display("[tlb_lru_page_translator_core] OK");
        end else begin
            $display("%0d mismatches, %0d results outstanding", mismatches, expected_xlat.size());
            $display("[tlb_lru_page_translator_core] ERROR");
        end
        $finish;
    end

endmodule

// ===== tlb_lru_page_translator_core.f =====
rtl/tlbt_pkg.sv
rtl/tlb_lru_page_translator_core.sv
tb/tlb_lru_page_translator_core_tb.sv
